>>> design/scsa_pkg.sv
// Shared constants for the size class split allocator: field widths, parameter
// defaults, status and action codes, and elaboration-time helper functions.
// No dependencies.
`timescale 1ns / 1ps

package scsa_pkg;

    // Fixed field widths of the request and response words.
    localparam int ADDR_W   = 18;
    localparam int REQ_W    = 16;
    localparam int PLIM_W   = 7;
    localparam int STATUS_W = 2;

    // Defaults for the top-level parameters.
    localparam int POOL_PAGES_DEF      = 64;
    localparam int PAGE_BYTES_DEF      = 4096;
    localparam int MIN_BLOCK_BYTES_DEF = 32;
    localparam int HEADER_BYTES_DEF    = 16;

    // The class table never grows past this many entries.
    localparam int MAX_CLASSES = 16;

    localparam logic [PLIM_W-1:0] PAGE_LIMIT_RESET = 7'd64;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd2;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Largest class whose block still fits in one page.
    function automatic int top_class(input int min_b, input int page_b);
        int c;
        c = 0;
        for (int k = 0; k < MAX_CLASSES - 1; k++) begin
            if (c == k && (longint'(min_b) << (k + 1)) <= longint'(page_b)) begin
                c = k + 1;
            end
        end
        return c;
    endfunction

    // Bits needed to index n entries, never less than one.
    function automatic int width_of(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

>>> design/scsa_if.sv
// Handshake interfaces for the allocator: the request channel and the
// response channel. Depends on scsa_pkg for the field widths.
`timescale 1ns / 1ps

interface scsa_req_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [scsa_pkg::REQ_W-1:0]  request_bytes;
    logic [scsa_pkg::ADDR_W-1:0] free_address;

    modport source(output valid, output action, output request_bytes,
                   output free_address, input ready);
    modport sink(input valid, input action, input request_bytes,
                 input free_address, output ready);
endinterface

interface scsa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [scsa_pkg::ADDR_W-1:0]   address;
    logic [scsa_pkg::STATUS_W-1:0] status;

    modport source(output valid, output address, output status, input ready);
    modport sink(input valid, input address, input status, output ready);
endinterface

>>> design/scsa_ram.sv
// Generic simple dual-port RAM: one write port, one read port with the
// read data registered. No dependencies.
`timescale 1ns / 1ps

module scsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/size_class_split_allocator.sv
// Power-of-two size class allocator over a pool of pages.
// Request channel i_req carries an allocate (action 0, request_bytes) or a
// free (action 1, free_address). Response channel o_rsp returns one word per
// request: the granted payload address and a status (ok, too large, pool
// exhausted); frees always answer address 0, status ok.
// The register page_limit is written through i_cfg_we / i_cfg_wdata; the
// user must do so only while the block is idle, which the block does
// not enforce. The register caps the pages taken from the bump pointer. One
// request is in flight at a time. An allocate goes through select, a pop if
// served from a list, one split step per level down to its class, and done;
// a fresh page splits from a whole page. A too large request or an exhausted
// pool goes from select to done. A free goes through divide, check, class
// lookup and done, skipping the lookup when its address is ignored. The
// response word shows up in the same cycle as the block is ready again.
// The split walk writes one free-list link per cycle. Results sit in an
// output register, so a stalled receiver only holds the block at its final
// step. Reset holds the request side off, empties all lists, zeroes the
// page count and restores page_limit to 64; the link and class memories
// need no clearing. Depends on scsa_pkg, scsa_if and scsa_ram.
`timescale 1ns / 1ps

module size_class_split_allocator #(
    parameter int POOL_PAGES      = scsa_pkg::POOL_PAGES_DEF,
    parameter int PAGE_BYTES      = scsa_pkg::PAGE_BYTES_DEF,
    parameter int MIN_BLOCK_BYTES = scsa_pkg::MIN_BLOCK_BYTES_DEF,
    parameter int HEADER_BYTES    = scsa_pkg::HEADER_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [scsa_pkg::PLIM_W-1:0] i_cfg_wdata,
    scsa_req_if.sink                    i_req,
    scsa_rsp_if.source                  o_rsp
);
    import scsa_pkg::*;

    localparam int SLOTS_PER_PAGE = PAGE_BYTES / MIN_BLOCK_BYTES;
    localparam int SLOT_COUNT     = POOL_PAGES * SLOTS_PER_PAGE;
    localparam int SLOT_W         = width_of(SLOT_COUNT);
    localparam int LINK_W         = $clog2(SLOT_COUNT + 1);
    localparam int TOP            = top_class(MIN_BLOCK_BYTES, PAGE_BYTES);
    localparam int NCLS           = TOP + 1;
    localparam int CLS_W          = width_of(NCLS);
    localparam int PU_W           = $clog2(POOL_PAGES + 1);
    localparam int NEED_W         = REQ_W + 1;
    localparam int MIN_LOG        = $clog2(MIN_BLOCK_BYTES);
    // Exact division by the block size via a reciprocal multiply.
    localparam int DIV_K          = ADDR_W + MIN_LOG;
    localparam int RECIP          = ((1 << DIV_K) + MIN_BLOCK_BYTES - 1) / MIN_BLOCK_BYTES;
    localparam int RECIP_W        = $clog2(RECIP + 1);
    localparam int PROD_W         = ADDR_W + RECIP_W;
    localparam int Q_W            = PROD_W - DIV_K;
    localparam int BASE_W         = (SLOT_W + MIN_LOG + 1 > ADDR_W) ?
                                    (SLOT_W + MIN_LOG + 1) : ADDR_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ASEL  = 3'd1;
    localparam logic [2:0] S_APOP  = 3'd2;
    localparam logic [2:0] S_SPLIT = 3'd3;
    localparam logic [2:0] S_FDIV  = 3'd4;
    localparam logic [2:0] S_FCHK  = 3'd5;
    localparam logic [2:0] S_FCLS  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    typedef logic [LINK_W-1:0] t_link;

    // Control state.
    logic [2:0]        r_state, n_state;
    logic [PLIM_W-1:0] r_plimit, n_plimit;
    logic [PU_W-1:0]   r_pages, n_pages;
    t_link             r_head [NCLS];
    t_link             n_head [NCLS];
    logic              r_out_valid, n_out_valid;

    // Payload registers.
    logic [CLS_W-1:0]    r_cls, n_cls;
    logic                r_ovr, n_ovr;
    logic [CLS_W-1:0]    r_j, n_j;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [ADDR_W-1:0]   r_off, n_off;
    logic                r_fok, n_fok;
    logic [Q_W-1:0]      r_quot, n_quot;
    logic [ADDR_W-1:0]   r_res_addr, n_res_addr;
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic [ADDR_W-1:0]   r_out_addr, n_out_addr;
    logic [STATUS_W-1:0] r_out_status, n_out_status;

    // Memory ports.
    logic              nl_we;
    logic [SLOT_W-1:0] nl_waddr;
    t_link             nl_wdata;
    logic [SLOT_W-1:0] nl_raddr;
    t_link             nl_rdata;
    logic              bc_we;
    logic [SLOT_W-1:0] bc_waddr;
    logic [CLS_W-1:0]  bc_wdata;
    logic [SLOT_W-1:0] bc_raddr;
    logic [CLS_W-1:0]  bc_rdata;

    scsa_ram #(.WIDTH(LINK_W), .DEPTH(SLOT_COUNT)) u_next_link (
        .i_clk  (i_clk),
        .i_we   (nl_we),
        .i_waddr(nl_waddr),
        .i_wdata(nl_wdata),
        .i_raddr(nl_raddr),
        .o_rdata(nl_rdata)
    );

    scsa_ram #(.WIDTH(CLS_W), .DEPTH(SLOT_COUNT)) u_block_class (
        .i_clk  (i_clk),
        .i_we   (bc_we),
        .i_waddr(bc_waddr),
        .i_wdata(bc_wdata),
        .i_raddr(bc_raddr),
        .o_rdata(bc_rdata)
    );

    // Class selection for the incoming request.
    logic [NEED_W-1:0] need;
    logic [NCLS-1:0]   fits;
    logic [CLS_W-1:0]  req_cls;

    always_comb begin
        need = NEED_W'(i_req.request_bytes) + NEED_W'(HEADER_BYTES);
        req_cls = CLS_W'(TOP);
        for (int k = 0; k < NCLS; k++) begin
            fits[k] = (32'(need) <= (32'(MIN_BLOCK_BYTES) << k));
        end
        for (int k = NCLS - 1; k >= 0; k--) begin
            if (fits[k]) begin
                req_cls = CLS_W'(k);
            end
        end
    end

    // Lowest non-empty list at or above the wanted class.
    logic [NCLS-1:0]  avail;
    logic             found;
    logic [CLS_W-1:0] fidx;

    always_comb begin
        found = 1'b0;
        fidx  = '0;
        for (int k = 0; k < NCLS; k++) begin
            avail[k] = (r_head[k] != '0) && (32'(k) >= 32'(r_cls));
        end
        for (int k = NCLS - 1; k >= 0; k--) begin
            if (avail[k]) begin
                found = 1'b1;
                fidx  = CLS_W'(k);
            end
        end
    end

    // Datapath helpers.
    t_link              pop_enc;
    t_link              pop_dec;
    logic [31:0]        page_lim;
    logic [31:0]        fresh_slot;
    logic [PROD_W-1:0]  prod;
    logic [31:0]        quot_ext;
    logic               free_ok;
    logic [CLS_W-1:0]   j_dn;
    logic [SLOT_W:0]    upper;
    logic [CLS_W-1:0]   free_cls;
    logic [BASE_W-1:0]  grant_addr;

    always_comb begin
        pop_enc    = r_head[fidx];
        pop_dec    = pop_enc - LINK_W'(1);
        if (32'(pop_dec) >= 32'(SLOT_COUNT)) begin
            pop_dec = '0;
        end
        page_lim   = (32'(r_plimit) < 32'(POOL_PAGES)) ? 32'(r_plimit) : 32'(POOL_PAGES);
        fresh_slot = 32'(r_pages) * 32'(SLOTS_PER_PAGE);
        prod       = PROD_W'(r_off) * PROD_W'(RECIP);
        quot_ext   = 32'(r_quot);
        free_ok    = r_fok && (quot_ext * 32'(MIN_BLOCK_BYTES) == 32'(r_off)) &&
                     (quot_ext < 32'(SLOT_COUNT));
        j_dn       = r_j - CLS_W'(1);
        upper      = (SLOT_W + 1)'(r_slot) + ((SLOT_W + 1)'(1) << j_dn);
        free_cls   = (32'(bc_rdata) > 32'(TOP)) ? '0 : bc_rdata;
        grant_addr = BASE_W'(r_slot) * BASE_W'(MIN_BLOCK_BYTES) + BASE_W'(HEADER_BYTES);
    end

    assign i_req.ready  = (r_state == S_IDLE) && i_rst_n;
    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.address = r_out_addr;
    assign o_rsp.status = r_out_status;

    always_comb begin
        n_state      = r_state;
        n_plimit     = r_plimit;
        n_pages      = r_pages;
        n_head       = r_head;
        n_out_valid  = r_out_valid;
        n_cls        = r_cls;
        n_ovr        = r_ovr;
        n_j          = r_j;
        n_slot       = r_slot;
        n_off        = r_off;
        n_fok        = r_fok;
        n_quot       = r_quot;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        n_out_addr   = r_out_addr;
        n_out_status = r_out_status;
        nl_we        = 1'b0;
        nl_waddr     = r_slot;
        nl_wdata     = '0;
        nl_raddr     = r_slot;
        bc_we        = 1'b0;
        bc_waddr     = r_slot;
        bc_wdata     = r_cls;
        bc_raddr     = r_slot;

        if (i_cfg_we) begin
            n_plimit = i_cfg_wdata;
        end
        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_cls = req_cls;
                    n_ovr = !fits[TOP];
                    n_fok = (i_req.free_address >= ADDR_W'(HEADER_BYTES));
                    n_off = i_req.free_address - ADDR_W'(HEADER_BYTES);
                    n_state = (i_req.action == ACT_FREE) ? S_FDIV : S_ASEL;
                end
            end
            S_ASEL: begin
                n_res_addr = '0;
                if (r_ovr) begin
                    n_res_status = ST_TOO_LARGE;
                    n_state = S_DONE;
                end else if (found) begin
                    n_slot   = pop_dec[SLOT_W-1:0];
                    nl_raddr = pop_dec[SLOT_W-1:0];
                    n_j      = fidx;
                    n_state  = S_APOP;
                end else if (32'(r_pages) >= page_lim) begin
                    n_res_status = ST_EXHAUSTED;
                    n_state = S_DONE;
                end else begin
                    n_slot  = fresh_slot[SLOT_W-1:0];
                    n_pages = r_pages + PU_W'(1);
                    n_j     = CLS_W'(TOP);
                    n_state = S_SPLIT;
                end
            end
            S_APOP: begin
                n_head[r_j] = nl_rdata;
                n_state = S_SPLIT;
            end
            S_SPLIT: begin
                if (r_j > r_cls) begin
                    // Upper half of the current block goes to the next class down.
                    if (32'(upper) < 32'(SLOT_COUNT)) begin
                        nl_we        = 1'b1;
                        nl_waddr     = upper[SLOT_W-1:0];
                        nl_wdata     = r_head[j_dn];
                        n_head[j_dn] = LINK_W'(upper) + LINK_W'(1);
                    end
                    n_j = j_dn;
                end else begin
                    bc_we        = 1'b1;
                    n_res_addr   = grant_addr[ADDR_W-1:0];
                    n_res_status = ST_OK;
                    n_state      = S_DONE;
                end
            end
            S_FDIV: begin
                n_quot  = prod[PROD_W-1:DIV_K];
                n_state = S_FCHK;
            end
            S_FCHK: begin
                n_res_addr   = '0;
                n_res_status = ST_OK;
                if (free_ok) begin
                    n_slot   = quot_ext[SLOT_W-1:0];
                    bc_raddr = quot_ext[SLOT_W-1:0];
                    n_state  = S_FCLS;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_FCLS: begin
                nl_we            = 1'b1;
                nl_waddr         = r_slot;
                nl_wdata         = r_head[free_cls];
                n_head[free_cls] = LINK_W'(r_slot) + LINK_W'(1);
                n_state          = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_addr   = r_res_addr;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_plimit    <= PAGE_LIMIT_RESET;
            r_pages     <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NCLS; k++) begin
                r_head[k] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_plimit    <= n_plimit;
            r_pages     <= n_pages;
            r_out_valid <= n_out_valid;
            r_head      <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cls        <= n_cls;
        r_ovr        <= n_ovr;
        r_j          <= n_j;
        r_slot       <= n_slot;
        r_off        <= n_off;
        r_fok        <= n_fok;
        r_quot       <= n_quot;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
        r_out_addr   <= n_out_addr;
        r_out_status <= n_out_status;
    end

endmodule

>>> tb/scsa_grant_checker.sv
// Checker for the size class split allocator: watches the request, response and
// configuration ports, predicts every response word and compares it in order.
// Depends on scsa_pkg and the handshake interfaces in scsa_if.
`timescale 1ns / 1ps

module scsa_grant_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [scsa_pkg::PLIM_W-1:0] i_cfg_wdata,
    scsa_req_if                         req_mon,
    scsa_rsp_if                         rsp_mon,
    output int unsigned                 o_mismatches,
    output int unsigned                 o_pending
);
    import scsa_pkg::*;

    localparam int POOL       = POOL_PAGES_DEF;
    localparam int PAGE       = PAGE_BYTES_DEF;
    localparam int MINB       = MIN_BLOCK_BYTES_DEF;
    localparam int HDR        = HEADER_BYTES_DEF;
    localparam int SLOTS_PP   = PAGE / MINB;
    localparam int SLOT_TOTAL = POOL * SLOTS_PP;
    localparam int TOP_CLS    = $clog2(PAGE / MINB);
    localparam int NCLS       = TOP_CLS + 1;

    typedef struct packed {
        logic [ADDR_W-1:0]   address;
        logic [STATUS_W-1:0] status;
    } t_grant;

    // Lists hold slot+1 so that zero marks an empty list or the end of one.
    logic [13:0]       head_q   [NCLS];
    logic [13:0]       link_mem [SLOT_TOTAL];
    logic [2:0]        cls_mem  [SLOT_TOTAL];
    logic [PLIM_W-1:0] pages_taken;
    logic [PLIM_W-1:0] page_cap;

    t_grant      expected_grants[$];
    t_grant      want;
    int unsigned mismatches;

    function automatic void push_block(input int cls, input int slot);
        link_mem[slot] = head_q[cls];
        head_q[cls]    = 14'(slot + 1);
    endfunction

    function automatic t_grant alloc_outcome(input logic act, input logic [REQ_W-1:0] nbytes,
                                             input logic [ADDR_W-1:0] faddr);
        t_grant r;
        int     need;
        int     cls;
        int     j;
        int     slot;
        int     off;
        int     lim;
        r.address = '0;
        r.status  = ST_OK;
        if (act == ACT_FREE) begin
            // Null, short, misaligned and out-of-pool addresses leave the lists alone.
            if (int'(faddr) >= HDR) begin
                off = int'(faddr) - HDR;
                if (off % MINB == 0 && off / MINB < SLOT_TOTAL) begin
                    slot = off / MINB;
                    push_block(int'(cls_mem[slot]), slot);
                end
            end
            return r;
        end
        need = int'(nbytes) + HDR;
        cls  = 0;
        while (cls < TOP_CLS && need > (MINB << cls)) cls++;
        if (need > (MINB << cls)) begin
            r.status = ST_TOO_LARGE;
            return r;
        end
        j = cls;
        while (j <= TOP_CLS && head_q[j] == '0) j++;
        if (j <= TOP_CLS) begin
            slot = int'(head_q[j]) - 1;
            if (slot >= SLOT_TOTAL) slot = 0;
            head_q[j] = link_mem[slot];
        end else begin
            lim = (int'(page_cap) < POOL) ? int'(page_cap) : POOL;
            if (int'(pages_taken) >= lim) begin
                r.status = ST_EXHAUSTED;
                return r;
            end
            slot        = int'(pages_taken) * SLOTS_PP;
            pages_taken = pages_taken + 1'b1;
            j           = TOP_CLS;
        end
        // Each split level hands its upper half to the next smaller class.
        while (j > cls) begin
            j--;
            if (slot + (1 << j) < SLOT_TOTAL) push_block(j, slot + (1 << j));
        end
        cls_mem[slot] = 3'(cls);
        r.address     = ADDR_W'(slot * MINB + HDR);
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NCLS; k++) head_q[k] = '0;
            for (int k = 0; k < SLOT_TOTAL; k++) begin
                link_mem[k] = '0;
                cls_mem[k]  = '0;
            end
            pages_taken = '0;
            page_cap    = PAGE_LIMIT_RESET;
            mismatches  = 0;
            expected_grants.delete();
        end else begin
            if (i_cfg_we) page_cap = i_cfg_wdata;
            if (rsp_mon.valid && rsp_mon.ready) begin
                if (expected_grants.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected response word: address %0d status %0d",
                                 rsp_mon.address, rsp_mon.status);
                end else begin
                    want = expected_grants.pop_front();
                    if (rsp_mon.address !== want.address ||
                        rsp_mon.status !== want.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %0d/%0d, got %0d/%0d (address/status)",
                                     want.address, want.status, rsp_mon.address,
                                     rsp_mon.status);
                    end
                end
            end
            if (req_mon.valid && req_mon.ready)
                expected_grants.push_back(alloc_outcome(req_mon.action, req_mon.request_bytes,
                                                        req_mon.free_address));
        end
        o_pending    <= expected_grants.size();
        o_mismatches <= mismatches;
    end

endmodule

>>> tb/testbench.sv
// Top of the allocator testbench: clock, reset, request words, receiver stalls,
// page_limit phases and the verdict. Depends on scsa_pkg, scsa_if, the
// allocator RTL and scsa_grant_checker.
`timescale 1ns / 1ps

module testbench;
    import scsa_pkg::*;

    localparam int IDLE_LIMIT    = 4000;
    localparam int PHASE_ITEMS   = 270;
    localparam int LONG_HOLD     = 400;
    localparam int HOLD_AFTER    = 700;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [PLIM_W-1:0] cfg_wdata;
    int unsigned       mismatches;
    int unsigned       pending;
    int unsigned       sent_cnt = 0;
    int                burst_left = 0;
    int                idle_cycles = 0;

    logic [ADDR_W-1:0] live_blocks[$];
    logic [ADDR_W-1:0] granted_hist[$];

    scsa_req_if req_if();
    scsa_rsp_if rsp_if();

    size_class_split_allocator u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    scsa_grant_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .req_mon     (req_if),
        .rsp_mon     (rsp_if),
        .o_mismatches(mismatches),
        .o_pending   (pending)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Granted addresses feed the frees of the random part.
    always @(posedge clk) begin
        if (rst_n && rsp_if.valid && rsp_if.ready && rsp_if.status == ST_OK &&
            rsp_if.address != '0) begin
            live_blocks.push_back(rsp_if.address);
            granted_hist.push_back(rsp_if.address);
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            idle_cycles <= 0;
        end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // The receiver changes its stall pattern at random among four modes, and once
    // holds off long enough for the block to back up into the request side.
    initial begin : rx_stalls
        int mode;
        int left;
        int hold;
        bit held_once;
        int tick;
        rsp_if.ready = 1'b0;
        mode      = 0;
        left      = 0;
        hold      = 0;
        held_once = 1'b0;
        tick      = 0;
        forever begin
            @(posedge clk);
            if (!held_once && sent_cnt >= HOLD_AFTER) begin
                hold      = LONG_HOLD;
                held_once = 1'b1;
            end
            if (hold > 0) begin
                hold--;
                rsp_if.ready <= 1'b0;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(20, 200);
                end
                left--;
                tick++;
                case (mode)
                    0: begin
                        rsp_if.ready <= 1'b1;
                    end
                    1: begin
                        rsp_if.ready <= 1'($urandom_range(0, 1));
                    end
                    2: begin
                        rsp_if.ready <= ($urandom_range(0, 3) == 0);
                    end
                    default: begin
                        rsp_if.ready <= (tick % 5) < 3;
                    end
                endcase
            end
        end
    end

    // Offers one request word and returns at the edge that accepts it. Words
    // go out in bursts with random gaps in between.
    task automatic send_item(input logic act, input logic [REQ_W-1:0] nbytes,
                             input logic [ADDR_W-1:0] faddr);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_if.valid         <= 1'b1;
        req_if.action        <= act;
        req_if.request_bytes <= nbytes;
        req_if.free_address  <= faddr;
        do @(posedge clk); while (!req_if.ready);
        sent_cnt++;
    endtask

    // Stops offering until every predicted response has come back.
    task automatic drain();
        req_if.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_page_limit(input logic [PLIM_W-1:0] value);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_item(input int big_pct);
        int                rr;
        int                sz;
        int                idx;
        logic [REQ_W-1:0]  nb;
        logic [ADDR_W-1:0] fa;
        rr = $urandom_range(0, 99);
        nb = REQ_W'($urandom);
        fa = ADDR_W'($urandom);
        if (rr >= 48 && rr < 83 && live_blocks.size() > 0) begin
            idx = $urandom_range(0, live_blocks.size() - 1);
            fa  = live_blocks[idx];
            live_blocks.delete(idx);
            send_item(ACT_FREE, nb, fa);
        end else if (rr >= 83 && rr < 88 && granted_hist.size() > 0) begin
            // Freeing an address again may push a block that is already listed.
            fa = granted_hist[$urandom_range(0, granted_hist.size() - 1)];
            send_item(ACT_FREE, nb, fa);
        end else if (rr >= 88 && rr < 93) begin
            send_item(ACT_FREE, nb, '0);
        end else if (rr >= 93) begin
            // Anything not one header past a slot boundary is ignored.
            if (fa[4:0] == 5'd16) fa[0] = ~fa[0];
            send_item(ACT_FREE, nb, fa);
        end else begin
            sz = $urandom_range(0, 99);
            if (sz < big_pct) begin
                nb = REQ_W'($urandom_range(2033, 4080));
            end else if (sz < big_pct + 5) begin
                nb = REQ_W'($urandom_range(0, 65535));
            end else if (sz < big_pct + 8) begin
                nb = REQ_W'($urandom_range(4081, 65535));
            end else begin
                sz = $urandom_range(0, 9);
                if (sz < 6) nb = REQ_W'($urandom_range(0, 120));
                else if (sz < 9) nb = REQ_W'($urandom_range(0, 1000));
                else nb = REQ_W'($urandom_range(0, 4080));
            end
            send_item(ACT_ALLOC, nb, fa);
        end
    endtask

    initial begin
        logic [PLIM_W-1:0] lim;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = '0;
        req_if.valid         = 1'b0;
        req_if.action        = ACT_ALLOC;
        req_if.request_bytes = '0;
        req_if.free_address  = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset page limit.
        send_item(ACT_FREE,  16'hFFFF, '0);
        send_item(ACT_ALLOC, 16'd0,    '0);
        send_item(ACT_ALLOC, 16'd16,   '0);
        send_item(ACT_ALLOC, 16'd17,   '0);
        send_item(ACT_ALLOC, 16'd4080, '0);
        send_item(ACT_ALLOC, 16'd4081, '0);
        send_item(ACT_ALLOC, 16'hFFFF, 18'h3FFFF);
        send_item(ACT_FREE,  16'd0,    18'd16);
        send_item(ACT_FREE,  16'd0,    18'd16);
        send_item(ACT_ALLOC, 16'd1,    '0);
        send_item(ACT_ALLOC, 16'd1,    '0);
        send_item(ACT_FREE,  16'd0,    18'd8);
        send_item(ACT_FREE,  16'd0,    18'd17);
        send_item(ACT_FREE,  16'd0,    18'h3FFFF);
        send_item(ACT_FREE,  16'd0,    18'd4112);
        send_item(ACT_ALLOC, 16'd2000, '0);
        send_item(ACT_ALLOC, 16'd100,  '0);
        send_item(ACT_FREE,  16'd0,    18'd80);
        send_item(ACT_ALLOC, 16'd48,   '0);
        send_item(ACT_ALLOC, 16'd4000, '0);
        drain();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: lim = 7'd1;
                1: lim = 7'd127;
                2: lim = 7'd0;
                3: lim = PLIM_W'($urandom_range(2, 63));
                4: lim = 7'd64;
                default: lim = PLIM_W'($urandom_range(1, 127));
            endcase
            write_page_limit(lim);
            // The second phase leans on whole-page blocks to run the pool dry.
            for (int n = 0; n < PHASE_ITEMS; n++) random_item((p == 1) ? 60 : 8);
            drain();
        end

        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
